FILE: design/sbrf_pkg.sv
// sbrf_pkg: types, codes and helpers shared by the square bitmap rotate/flip block
// no dependencies; used by sbrf_ctrl, sbrf_dp, the top level and the bench
`default_nettype none

package sbrf_pkg;

    // fixed field widths
    localparam int ROW_W = 32;
    localparam int IDX_W = 5;
    localparam int SIZE_W = 6;
    localparam int KIND_W = 3;

    // opcode of an input word
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    // transform kinds
    localparam logic [KIND_W-1:0] KIND_ROT_R  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ROT_L  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FLIP_H = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLIP_V = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NEG    = 3'd4;

    // configuration register addresses
    localparam logic [2:0] CFG_ADDR_SIZE = 3'd0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             start;
        logic             step;
        logic             emit;
        logic             last;
        logic             swap;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

    // side in use: at least 1, at most the row count of the store
    function automatic logic [SIZE_W-1:0] side_of(input logic [SIZE_W-1:0] size,
                                                 input logic [SIZE_W-1:0] depth);
        logic [SIZE_W-1:0] n;
        n = size;
        if (n == '0) n = 6'd1;
        if (n > depth) n = depth;
        return n;
    endfunction

    // ones on the columns inside the side
    function automatic logic [ROW_W-1:0] mask_of(input logic [SIZE_W-1:0] n);
        logic [ROW_W-1:0] m;
        if (n >= 6'd32) m = '1;
        else m = (32'h1 << n) - 32'h1;
        return m;
    endfunction

    // bit order reversal of a full row
    function automatic logic [ROW_W-1:0] rev_row(input logic [ROW_W-1:0] v);
        logic [ROW_W-1:0] r;
        for (int k = 0; k < ROW_W; k++) r[k] = v[ROW_W-1-k];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/sbrf_ctrl.sv
// sbrf_ctrl: sequencer of the rotate/flip block, loads and the row sweep of a transform
// depends on sbrf_pkg; drives sbrf_dp through t_cmd and reads t_sts
`default_nettype none

module sbrf_ctrl #(
    parameter int DEPTH = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    input  wire                         i_in_op,
    input  wire  [sbrf_pkg::SIZE_W-1:0] i_side,
    input  sbrf_pkg::t_sts              i_sts,
    output logic                        o_in_ready,
    output sbrf_pkg::t_cmd              o_cmd
);

    localparam logic [sbrf_pkg::IDX_W-1:0] LAST_IDX = sbrf_pkg::IDX_W'(DEPTH - 1);

    sbrf_pkg::t_state r_state, n_state;
    logic [sbrf_pkg::IDX_W-1:0] r_idx, n_idx;
    logic acc, in_img, step;

    // row sweep bookkeeping
    assign o_in_ready = (r_state == sbrf_pkg::ST_IDLE);
    assign acc = i_in_valid & o_in_ready;
    assign in_img = ({1'b0, r_idx} < i_side);
    assign step = (r_state == sbrf_pkg::ST_RUN) && (in_img ? i_sts.out_free : 1'b1);

    always_comb begin
        o_cmd.load  = acc && (i_in_op == sbrf_pkg::OP_LOAD);
        o_cmd.start = acc && (i_in_op == sbrf_pkg::OP_XFORM);
        o_cmd.step  = step;
        o_cmd.emit  = step && in_img;
        o_cmd.last  = ({1'b0, r_idx} == (i_side - 6'd1));
        o_cmd.swap  = step && (r_idx == LAST_IDX);
        o_cmd.idx   = r_idx;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        case (r_state)
            sbrf_pkg::ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = sbrf_pkg::ST_RUN;
                    n_idx = '0;
                end
            end
            sbrf_pkg::ST_RUN: begin
                if (step) begin
                    n_idx = r_idx + 5'd1;
                    if (r_idx == LAST_IDX) n_state = sbrf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sbrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbrf_pkg::ST_IDLE;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

FILE: design/sbrf_dp.sv
// sbrf_dp: two banks of image rows, the row transform and the output word register
// depends on sbrf_pkg; commanded by sbrf_ctrl
`default_nettype none

module sbrf_dp #(
    parameter int DEPTH = 32
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  sbrf_pkg::t_cmd              i_cmd,
    input  wire  [sbrf_pkg::IDX_W-1:0]  i_row_index,
    input  wire  [sbrf_pkg::ROW_W-1:0]  i_row_pixels,
    input  wire  [sbrf_pkg::KIND_W-1:0] i_kind,
    input  wire  [sbrf_pkg::SIZE_W-1:0] i_side,
    input  wire                         i_out_ready,
    output sbrf_pkg::t_sts              o_sts,
    output logic                        o_out_valid,
    output logic [sbrf_pkg::IDX_W-1:0]  o_out_row_index,
    output logic [sbrf_pkg::ROW_W-1:0]  o_out_row_pixels,
    output logic                        o_out_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [sbrf_pkg::ROW_W-1:0] r_img0 [DEPTH];
    logic [sbrf_pkg::ROW_W-1:0] r_img1 [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic r_sel;
    logic [sbrf_pkg::KIND_W-1:0] r_kind;
    logic r_out_valid;
    logic [sbrf_pkg::IDX_W-1:0] r_out_idx;
    logic [sbrf_pkg::ROW_W-1:0] r_out_pix;
    logic r_out_last;

    logic [sbrf_pkg::ROW_W-1:0] mask, col, rd_raw, rd_old, fresh, wr_row;
    logic [sbrf_pkg::SIZE_W-1:0] rev_i, shamt;
    logic [sbrf_pkg::IDX_W-1:0] col_sel;
    logic [AW-1:0] rd_addr;
    logic in_img;
    logic load_ok;

    assign mask = sbrf_pkg::mask_of(i_side);
    assign rev_i = i_side - 6'd1 - {1'b0, i_cmd.idx};
    assign shamt = 6'd32 - i_side;
    assign in_img = ({1'b0, i_cmd.idx} < i_side);
    assign col_sel = (r_kind == sbrf_pkg::KIND_ROT_R) ? i_cmd.idx : rev_i[sbrf_pkg::IDX_W-1:0];
    assign rd_addr = (in_img && r_kind == sbrf_pkg::KIND_FLIP_V) ? rev_i[AW-1:0]
                                                                : i_cmd.idx[AW-1:0];
    assign load_ok = ({1'b0, i_row_index} < sbrf_pkg::SIZE_W'(DEPTH));

    // row read from the active bank, unwritten rows read as zero
    always_comb begin
        rd_raw = '0;
        if (r_vld[rd_addr]) rd_raw = r_sel ? r_img1[rd_addr] : r_img0[rd_addr];
        rd_old = rd_raw & mask;
    end

    // column gather: each row contributes its pixel at the selected column
    always_comb begin
        logic [sbrf_pkg::ROW_W-1:0] row_r;
        col = '0;
        for (int r = 0; r < DEPTH; r++) begin
            row_r = '0;
            if (r_vld[r]) row_r = (r_sel ? r_img1[r] : r_img0[r]) & mask;
            col[r] = row_r[col_sel];
        end
    end

    // new row of the transformed image
    always_comb begin
        case (r_kind)
            sbrf_pkg::KIND_ROT_R:  fresh = sbrf_pkg::rev_row(col) >> shamt;
            sbrf_pkg::KIND_ROT_L:  fresh = col & mask;
            sbrf_pkg::KIND_FLIP_H: fresh = sbrf_pkg::rev_row(rd_old) >> shamt;
            sbrf_pkg::KIND_FLIP_V: fresh = rd_old;
            sbrf_pkg::KIND_NEG:    fresh = ~rd_old & mask;
            default:               fresh = rd_old;
        endcase
        wr_row = in_img ? fresh : rd_raw;
    end

    // image banks: loads go to the active bank, a sweep fills the other one
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            if (r_sel) r_img1[i_row_index[AW-1:0]] <= i_row_pixels;
            else r_img0[i_row_index[AW-1:0]] <= i_row_pixels;
        end
        if (i_cmd.step) begin
            if (r_sel) r_img0[i_cmd.idx[AW-1:0]] <= wr_row;
            else r_img1[i_cmd.idx[AW-1:0]] <= wr_row;
        end
        if (i_cmd.start) r_kind <= i_kind;
    end

    // row valid bits and bank select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_sel <= 1'b0;
        end else begin
            if (i_cmd.load && load_ok) r_vld[i_row_index[AW-1:0]] <= 1'b1;
            if (i_cmd.swap) begin
                r_vld <= '1;
                r_sel <= ~r_sel;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_idx <= i_cmd.idx;
            r_out_pix <= fresh;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_sts.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_row_index = r_out_idx;
    assign o_out_row_pixels = r_out_pix;
    assign o_out_last = r_out_last;

endmodule

`default_nettype wire

FILE: design/square_bitmap_rotate_flip.sv
// square_bitmap_rotate_flip: square one-bit image store with quarter turns, flips, negative
// load word: written in the cycle it is accepted. transform word: a sweep over all min(MAX_SIDE,32)
// rows of the store whatever the side, one row a cycle while the output is free, stalling when not
// first output word: the run state is entered, then row 0 is registered in the output word register;
// next input taken when the sweep ends. reset: image reads all zero at once through per-row valid bits,
// no clearing pass; image_size returns to 32, output empty
`default_nettype none

module square_bitmap_rotate_flip #(
    parameter int MAX_SIDE = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // row_index[4:0], row_pixels[36:5], transform_kind[39:37]
    input  wire  [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // out_row_index[4:0], out_row_pixels[36:5], zero[39:37]
    output logic        m_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = (MAX_SIDE < 32) ? MAX_SIDE : 32;

    logic [sbrf_pkg::SIZE_W-1:0] r_image_size;
    logic [sbrf_pkg::SIZE_W-1:0] side;
    sbrf_pkg::t_cmd cmd;
    sbrf_pkg::t_sts sts;
    logic [sbrf_pkg::IDX_W-1:0] out_idx;
    logic [sbrf_pkg::ROW_W-1:0] out_pix;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= sbrf_pkg::SIZE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == sbrf_pkg::CFG_ADDR_SIZE) begin
            r_image_size <= pwdata[sbrf_pkg::SIZE_W-1:0];
        end
    end
    assign prdata = (paddr == sbrf_pkg::CFG_ADDR_SIZE) ? {26'd0, r_image_size} : 32'd0;

    assign side = sbrf_pkg::side_of(r_image_size, sbrf_pkg::SIZE_W'(DEPTH));

    sbrf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_in_op    (s_tuser[0]),
        .i_side     (side),
        .i_sts      (sts),
        .o_in_ready (s_tready),
        .o_cmd      (cmd)
    );

    sbrf_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_row_index      (s_tdata[4:0]),
        .i_row_pixels     (s_tdata[36:5]),
        .i_kind           (s_tdata[39:37]),
        .i_side           (side),
        .i_out_ready      (m_tready),
        .o_sts            (sts),
        .o_out_valid      (m_tvalid),
        .o_out_row_index  (out_idx),
        .o_out_row_pixels (out_pix),
        .o_out_last       (m_tlast)
    );

    assign m_tdata = {3'd0, out_pix, out_idx};

endmodule

`default_nettype wire

FILE: design/sbrf_chk.sv
// sbrf_chk: port-level checks of square_bitmap_rotate_flip, bound to the top level
// depends only on the top level's ports
`default_nettype none

module sbrf_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [0:0]  s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire        m_tlast,
    input wire        pready
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // input side closes only after a transform word
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tuser[0]))
        else $error("input closed without a transform word");

    // while a row short of the last is waiting the sweep is still running
    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open in the middle of an image");

    // padding bits of the output word stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[39:37] == 3'd0) && pready)
        else $error("output padding not zero");

endmodule

bind square_bitmap_rotate_flip sbrf_chk u_sbrf_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

`default_nettype wire

FILE: dv/tb.sv
// tb: self-checking bench for square_bitmap_rotate_flip, stream words in and rows out
// with an in-bench image predictor; needs sbrf_pkg and the block's top level only
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SWEEP_WAIT  = 40;    // one full sweep plus margin
    localparam int HOLD_CYCLES = 300;   // long output back-pressure
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 37;
    localparam int STORE_ROWS  = 32;

    // transform kinds with no defined meaning, image passes through
    localparam logic [sbrf_pkg::KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [sbrf_pkg::KIND_W-1:0] KIND_SPARE_MID = 3'd6;
    localparam logic [sbrf_pkg::KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

    typedef enum logic { DIR_WORD, DIR_CFG } t_dir_kind;

    typedef struct {
        t_dir_kind                   rk;
        logic                        op;
        logic [sbrf_pkg::IDX_W-1:0]  ridx;
        logic [sbrf_pkg::ROW_W-1:0]  pix;
        logic [sbrf_pkg::KIND_W-1:0] xk;
        logic [sbrf_pkg::SIZE_W-1:0] side;
        logic                        typed_on;
        logic [sbrf_pkg::ROW_W-1:0]  typed_pix;
    } t_dir_row;

    typedef struct {
        logic [sbrf_pkg::IDX_W-1:0] idx;
        logic [sbrf_pkg::ROW_W-1:0] pix;
        logic                       last;
    } t_row_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // row_index[4:0], row_pixels[36:5], transform_kind[39:37]
    logic [0:0]  s_tuser;   // opcode[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_row_index[4:0], out_row_pixels[36:5], zero[39:37]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [sbrf_pkg::ROW_W-1:0]  image_rows [STORE_ROWS];
    logic [sbrf_pkg::SIZE_W-1:0] side_reg;
    t_row_exp                    pending_rows [$];
    t_dir_row                    stim_tab [$];

    // shared between driver and monitor
    logic                        typed_on;
    logic [sbrf_pkg::ROW_W-1:0]  typed_pix;
    logic                        idle_on;
    logic                        hold_req;
    int                          fail_count;
    int                          cycles;

    square_bitmap_rotate_flip i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // new image from the stored one, rows queued in emit order
    function automatic void transform_image(input logic [sbrf_pkg::KIND_W-1:0] xk);
        int n;
        logic [sbrf_pkg::ROW_W-1:0] mask;
        logic [sbrf_pkg::ROW_W-1:0] src [STORE_ROWS];
        logic [sbrf_pkg::ROW_W-1:0] dst [STORE_ROWS];
        t_row_exp e;
        n = side_reg;
        if (n < 1) n = 1;
        if (n > 32) n = 32;
        mask = (n >= 32) ? '1 : ((32'h1 << n) - 32'h1);
        for (int r = 0; r < STORE_ROWS; r++) src[r] = image_rows[r] & mask;
        for (int i = 0; i < n; i++) begin
            dst[i] = '0;
            case (xk)
                sbrf_pkg::KIND_ROT_R: begin
                    for (int j = 0; j < n; j++) dst[i][j] = src[n-1-j][i];
                end
                sbrf_pkg::KIND_ROT_L: begin
                    for (int j = 0; j < n; j++) dst[i][j] = src[j][n-1-i];
                end
                sbrf_pkg::KIND_FLIP_H: begin
                    for (int j = 0; j < n; j++) dst[i][j] = src[i][n-1-j];
                end
                sbrf_pkg::KIND_FLIP_V: dst[i] = src[n-1-i];
                sbrf_pkg::KIND_NEG:    dst[i] = ~src[i] & mask;
                default:               dst[i] = src[i];
            endcase
        end
        // rows beyond the side stay as stored
        for (int i = 0; i < n; i++) begin
            image_rows[i] = dst[i];
            e.idx  = i[sbrf_pkg::IDX_W-1:0];
            e.pix  = typed_on ? typed_pix : dst[i];
            e.last = (i == n - 1);
            pending_rows.push_back(e);
        end
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // output check, then prediction of the accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (pending_rows.size() == 0) begin
                    $error("unexpected row: out_row_index %0d", m_tdata[4:0]);
                    fail_count++;
                end else begin
                    t_row_exp e;
                    e = pending_rows.pop_front();
                    if (m_tdata[4:0] !== e.idx) begin
                        $error("out_row_index expected %0d got %0d", e.idx, m_tdata[4:0]);
                        fail_count++;
                    end
                    if (m_tdata[36:5] !== e.pix) begin
                        $error("out_row_pixels expected %h got %h", e.pix, m_tdata[36:5]);
                        fail_count++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_row expected %0d got %0d", e.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == sbrf_pkg::OP_LOAD) image_rows[s_tdata[4:0]] = s_tdata[36:5];
                else transform_image(s_tdata[39:37]);
            end
        end
    end

    // output side: random stalls, one long hold when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one input word, with an optional gap in front
    task automatic send_word(input logic op, input logic [sbrf_pkg::IDX_W-1:0] ridx,
                             input logic [sbrf_pkg::ROW_W-1:0] pix,
                             input logic [sbrf_pkg::KIND_W-1:0] xk);
        int g;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            g = $urandom_range(1, 12);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {xk, pix, ridx};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // stop offering, drain, let the sweep settle
    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SWEEP_WAIT) @(posedge i_clk);
    endtask

    // register write: setup then access, then read back
    task automatic write_side(input logic [sbrf_pkg::SIZE_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= sbrf_pkg::CFG_ADDR_SIZE;
        pwdata  <= {26'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        side_reg = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== {26'd0, val}) begin
            $error("image_size expected %0d got %0d", val, prdata);
            fail_count++;
        end
    endtask

    task automatic add_word(input logic op, input logic [sbrf_pkg::IDX_W-1:0] ridx,
                            input logic [sbrf_pkg::ROW_W-1:0] pix,
                            input logic [sbrf_pkg::KIND_W-1:0] xk,
                            input logic t_on, input logic [sbrf_pkg::ROW_W-1:0] t_pix);
        stim_tab.push_back('{DIR_WORD, op, ridx, pix, xk, 6'd0, t_on, t_pix});
    endtask

    task automatic add_cfg(input logic [sbrf_pkg::SIZE_W-1:0] val);
        stim_tab.push_back('{DIR_CFG, sbrf_pkg::OP_LOAD, 5'd0, 32'd0, sbrf_pkg::KIND_ROT_R,
                             val, 1'b0, 32'd0});
    endtask

    // main sequence
    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_rst_n  = 1'b0;
        typed_on = 1'b0;
        typed_pix = '0;
        idle_on  = 1'b1;
        hold_req = 1'b0;
        fail_count = 0;
        cycles   = 0;
        side_reg = sbrf_pkg::SIZE_RESET;
        for (int r = 0; r < STORE_ROWS; r++) image_rows[r] = '0;

        // directed rows: reset image, extremes, every kind, side corner cases
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, sbrf_pkg::KIND_NEG, 1'b1, 32'hFFFF_FFFF);
        add_word(sbrf_pkg::OP_XFORM, 5'd31, 32'hFFFF_FFFF, sbrf_pkg::KIND_NEG, 1'b1, 32'h0);
        add_word(sbrf_pkg::OP_LOAD, 5'd0, 32'hFFFF_FFFF, sbrf_pkg::KIND_ROT_R, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_LOAD, 5'd31, 32'h8000_0001, KIND_SPARE_HI, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_LOAD, 5'd5, 32'hA5A5_A5A5, sbrf_pkg::KIND_ROT_R, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_LOAD, 5'd17, 32'h5A5A_5A5A, sbrf_pkg::KIND_ROT_R, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, sbrf_pkg::KIND_ROT_R, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, sbrf_pkg::KIND_ROT_L, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, sbrf_pkg::KIND_FLIP_H, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, sbrf_pkg::KIND_FLIP_V, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, KIND_SPARE_LO, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, KIND_SPARE_HI, 1'b0, 32'd0);
        // single pixel image
        add_cfg(6'd1);
        add_word(sbrf_pkg::OP_LOAD, 5'd0, 32'hFFFF_FFFF, sbrf_pkg::KIND_ROT_R, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, sbrf_pkg::KIND_NEG, 1'b1, 32'h0);
        // zero side is raised to one
        add_cfg(6'd0);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, sbrf_pkg::KIND_NEG, 1'b1, 32'h1);
        // oversize side is cut to the store
        add_cfg(6'd63);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, sbrf_pkg::KIND_FLIP_V, 1'b0, 32'd0);
        // rows and columns outside a small side
        add_cfg(6'd5);
        add_word(sbrf_pkg::OP_LOAD, 5'd20, 32'h1234_5678, sbrf_pkg::KIND_ROT_R, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_LOAD, 5'd3, 32'hFFFF_FFFF, sbrf_pkg::KIND_ROT_R, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, sbrf_pkg::KIND_ROT_L, 1'b0, 32'd0);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, KIND_SPARE_MID, 1'b0, 32'd0);
        add_cfg(6'd32);
        add_word(sbrf_pkg::OP_XFORM, 5'd0, 32'd0, sbrf_pkg::KIND_ROT_R, 1'b0, 32'd0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_tab[k]) begin
            if (stim_tab[k].rk == DIR_CFG) begin
                wait_idle();
                write_side(stim_tab[k].side);
            end else begin
                // takes effect after the monitor has seen the previous word
                typed_on  <= stim_tab[k].typed_on;
                typed_pix <= stim_tab[k].typed_pix;
                send_word(stim_tab[k].op, stim_tab[k].ridx, stim_tab[k].pix, stim_tab[k].xk);
            end
        end
        typed_on <= 1'b0;

        // random phases, each at its own side
        for (int p = 0; p < PHASES; p++) begin
            logic [sbrf_pkg::SIZE_W-1:0] sv;
            case (p)
                0:       sv = 6'd32;
                1:       sv = 6'd1;
                2:       sv = 6'd0;
                3:       sv = 6'd63;
                4:       sv = 6'd2;
                5:       sv = 6'd31;
                6:       sv = 6'd33;
                default: sv = sbrf_pkg::SIZE_W'($urandom_range(0, 63));
            endcase
            wait_idle();
            write_side(sv);
            idle_on = (p < PHASES - 2);
            if (p == 3) hold_req = 1'b1;
            for (int w = 0; w < PHASE_WORDS; w++) begin
                logic [sbrf_pkg::ROW_W-1:0] px;
                logic [sbrf_pkg::KIND_W-1:0] xk;
                case ($urandom_range(0, 9))
                    0:       px = '0;
                    1:       px = '1;
                    default: px = $urandom;
                endcase
                xk = ($urandom_range(0, 9) == 0) ? sbrf_pkg::KIND_W'($urandom_range(5, 7))
                                                 : sbrf_pkg::KIND_W'($urandom_range(0, 4));
                send_word(($urandom_range(0, 9) < 7) ? sbrf_pkg::OP_LOAD : sbrf_pkg::OP_XFORM,
                          sbrf_pkg::IDX_W'($urandom_range(0, 31)), px, xk);
            end
        end

        // drain and finish
        wait_idle();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/sbrf_pkg.sv
design/sbrf_ctrl.sv
design/sbrf_dp.sv
design/square_bitmap_rotate_flip.sv
design/sbrf_chk.sv
dv/tb.sv
